/* hw/rtl/pacm_pkg.sv */
// Shared types, widths, constants and tables for the pointer angle to cursor mapper.
`timescale 1ns / 1ps

package pacm_pkg;

    // Field widths.
    localparam int DIR_W      = 16;
    localparam int PIX_W      = 14;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 14;

    // Defaults for the top-level parameters.
    localparam int RING_LEN_DEF   = 4;
    localparam int ANGLE_ITER_DEF = 16;

    // CORDIC datapath.
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 23;
    localparam int CX_W       = 28;
    localparam int Z_W        = 26;

    // Fraction and shared multiplier.
    localparam int NUM_W    = 23;
    localparam int FRAC_W   = 17;
    localparam int DIV_W    = 7;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 24;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int RECIP_SH = 32;

    // Angles in degrees times 65536.
    localparam logic signed [Z_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [Z_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [Z_W-1:0] OFF_X  = 26'sd3932160;
    localparam logic signed [Z_W-1:0] LIM_X  = 26'sd7864320;
    localparam logic signed [Z_W-1:0] OFF_Y  = 26'sd2949120;
    localparam logic signed [Z_W-1:0] LIM_Y  = 26'sd5898240;

    // Divisors of the offset angle span and their reciprocals, scaled by 2^32.
    localparam logic [DIV_W-1:0]   DIV_X   = 7'd120;
    localparam logic [DIV_W-1:0]   DIV_Y   = 7'd90;
    localparam logic [MUL_A_W-1:0] RECIP_X = 26'd35791394;
    localparam logic [MUL_A_W-1:0] RECIP_Y = 26'd47721858;

    localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [PIX_W-1:0]  PIX_MAX = 14'h3FFF;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] X_ORIGIN_RST    = 14'd0;
    localparam logic [CFG_DATA_W-1:0] Y_ORIGIN_RST    = 14'd1080;
    localparam logic [CFG_DATA_W-1:0] PANE_WIDTH_RST  = 14'd1920;
    localparam logic [CFG_DATA_W-1:0] PANE_HEIGHT_RST = 14'd1080;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PANE_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PANE_HEIGHT = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ROT,
        S_FRAC,
        S_DMUL,
        S_DCOR,
        S_PMX,
        S_PMY,
        S_ROW,
        S_RING,
        S_AMX,
        S_AMY,
        S_ACY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_ring_ctl;

    // atan(2^-i) in degrees times 65536, rounded to nearest.
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    function automatic int sum_w(input int len);
        return PIX_W + $clog2(len);
    endfunction

    function automatic int ptr_w(input int len);
        return (len > 1) ? $clog2(len) : 1;
    endfunction

endpackage

/* hw/rtl/pacm_dir_if.sv */
// Handshake interface carrying one pointing-direction vector.
`timescale 1ns / 1ps

interface pacm_dir_if
    import pacm_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

/* hw/rtl/pacm_cursor_if.sv */
// Handshake interface carrying one averaged cursor position.
`timescale 1ns / 1ps

interface pacm_cursor_if
    import pacm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] cursor_x;
    logic [PIX_W-1:0] cursor_y;

    modport source (output valid, output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

/* hw/rtl/pacm_ring.sv */
// Moving-average ring: point memory, valid bits, write pointer and running sums.
`timescale 1ns / 1ps

module pacm_ring
    import pacm_pkg::*;
#(
    parameter int RING_LEN = RING_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ring_ctl                      i_ctl,
    input  logic [PIX_W-1:0]               i_px,
    input  logic [PIX_W-1:0]               i_py,
    output logic [sum_w(RING_LEN)-1:0]     o_sum_x,
    output logic [sum_w(RING_LEN)-1:0]     o_sum_y
);

    localparam int SUM_W = sum_w(RING_LEN);
    localparam int PTR_W = ptr_w(RING_LEN);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_LEN - 1);

    logic [PIX_W-1:0]    r_mem_x [RING_LEN];
    logic [PIX_W-1:0]    r_mem_y [RING_LEN];
    logic [PIX_W-1:0]    r_rd_x;
    logic [PIX_W-1:0]    r_rd_y;
    logic                r_rd_vld;
    logic [RING_LEN-1:0] r_vld;
    logic [PTR_W-1:0]    r_ptr;
    logic [SUM_W-1:0]    r_sum_x;
    logic [SUM_W-1:0]    r_sum_y;

    logic [PIX_W-1:0] old_x;
    logic [PIX_W-1:0] old_y;

    // An entry never written since reset counts as zero.
    assign old_x = r_rd_vld ? r_rd_x : '0;
    assign old_y = r_rd_vld ? r_rd_y : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem_x[r_ptr] <= i_px;
            r_mem_y[r_ptr] <= i_py;
        end
        if (i_ctl.rd) begin
            r_rd_x <= r_mem_x[r_ptr];
            r_rd_y <= r_mem_y[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_ptr    <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
        end else begin
            if (i_ctl.rd) begin
                r_rd_vld <= r_vld[r_ptr];
            end
            if (i_ctl.wr) begin
                r_sum_x      <= r_sum_x - SUM_W'(old_x) + SUM_W'(i_px);
                r_sum_y      <= r_sum_y - SUM_W'(old_y) + SUM_W'(i_py);
                r_vld[r_ptr] <= 1'b1;
                r_ptr        <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
            end
        end
    end

    assign o_sum_x = r_sum_x;
    assign o_sum_y = r_sum_y;

endmodule

/* hw/rtl/pointer_angle_to_cursor_mapper_core.sv */
// Top level of the pointer angle to cursor mapper: sequencer, CORDIC, multiplier, registers.
`timescale 1ns / 1ps

// Channel   | Direction | Payload                         | Transaction when
// ----------+-----------+---------------------------------+------------------------------
// i_dir     | in        | dir_x, dir_y, dir_z (Q1.14)     | valid and ready high at edge
// o_cursor  | out       | cursor_x, cursor_y (pixels)     | valid and ready high at edge
// i_cfg_*   | in        | index, 14-bit data              | i_cfg_we high at edge
//
// The time from one input transaction to the next is set by the single CORDIC
// add/shift unit running once per axis and by the one shared multiplier used up
// to six times.
// An axis whose forward component is zero or negative skips its rotations, and a
// clamped fraction skips its division, so such items finish sooner.
// Reset is synchronous and active low; it clears the ring's valid bits at once,
// so no clearing pass is needed. A finished result waits in the output register
// while the next item is accepted; only a second result stalls on o_cursor.ready.

module pointer_angle_to_cursor_mapper_core
    import pacm_pkg::*;
#(
    parameter int RING_LEN         = RING_LEN_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pacm_dir_if.sink              i_dir,
    pacm_cursor_if.source         o_cursor,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = sum_w(RING_LEN);
    localparam logic [ATAN_IDX_W-1:0] ITER_LAST = ATAN_IDX_W'(ANGLE_ITERATIONS - 1);
    // Reciprocal of the ring length, scaled so that any sum divides with at most
    // one correction step.
    localparam logic [MUL_A_W-1:0] RECIP_L = MUL_A_W'((64'd1 << SUM_W) / RING_LEN);
    localparam logic [SUM_W:0]     LEN_V   = (SUM_W + 1)'(RING_LEN);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_x_origin;
    logic [CFG_DATA_W-1:0] r_y_origin;
    logic [CFG_DATA_W-1:0] r_pane_width;
    logic [CFG_DATA_W-1:0] r_pane_height;

    // Control state.
    t_state                r_state;
    t_state                n_state;
    logic                  r_axis;
    logic [ATAN_IDX_W-1:0] r_iter;
    logic                  r_out_vld;
    logic                  n_out_vld;

    // Datapath registers.
    logic signed [DIR_W-1:0] r_dx;
    logic signed [DIR_W-1:0] r_dy;
    logic signed [DIR_W-1:0] r_dz;
    logic signed [CX_W-1:0]  r_cx;
    logic signed [CX_W-1:0]  r_cy;
    logic signed [Z_W-1:0]   r_z;
    logic [NUM_W-1:0]        r_num;
    logic [PROD_W-1:0]       r_prod;
    logic [FRAC_W-1:0]       r_fx;
    logic [FRAC_W-1:0]       r_fy;
    logic [PIX_W-1:0]        r_px;
    logic [PIX_W-1:0]        r_py;
    logic [PIX_W-1:0]        r_avg_x;
    logic [PIX_W-1:0]        r_avg_y;
    logic [PIX_W-1:0]        r_cur_x;
    logic [PIX_W-1:0]        r_cur_y;

    // Combinational signals.
    logic                    in_accept;
    logic                    out_load;
    logic                    mul_en;
    t_ring_ctl               ring_ctl;
    t_state                  axis_next;
    logic signed [DIR_W-1:0] comp;
    logic signed [Z_W-1:0]   sel_off;
    logic signed [Z_W-1:0]   sel_lim;
    logic [MUL_A_W-1:0]      sel_recip;
    logic [DIV_W-1:0]        sel_div;
    logic signed [CX_W-1:0]  sh_x;
    logic signed [CX_W-1:0]  sh_y;
    logic signed [Z_W-1:0]   atan_z;
    logic signed [Z_W-1:0]   n_full;
    logic                    frac_lo;
    logic                    frac_hi;
    logic [FRAC_W-1:0]       q0;
    logic [NUM_W+1:0]        rem;
    logic [FRAC_W-1:0]       div_q;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [PIX_W:0]          px_sum;
    logic [PIX_W-1:0]        px;
    logic signed [31:0]      rowq;
    logic [PIX_W-1:0]        py;
    logic [SUM_W-1:0]        sum_x;
    logic [SUM_W-1:0]        sum_y;
    logic [SUM_W-1:0]        asum;
    logic [PIX_W:0]          aq0;
    logic [SUM_W:0]          arem;
    logic [PIX_W:0]          aq;

    pacm_ring #(
        .RING_LEN (RING_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_sum_x (sum_x),
        .o_sum_y (sum_y)
    );

    assign in_accept = i_dir.valid && i_dir.ready;
    assign out_load  = (r_state == S_DONE) && (!r_out_vld || o_cursor.ready);

    // The horizontal axis is handled first, then the vertical one, with the same
    // rotation unit and with the divider constants picked by r_axis.
    assign comp      = r_axis ? r_dz : r_dx;
    assign sel_off   = r_axis ? OFF_Y : OFF_X;
    assign sel_lim   = r_axis ? LIM_Y : LIM_X;
    assign sel_recip = r_axis ? RECIP_Y : RECIP_X;
    assign sel_div   = r_axis ? DIV_Y : DIV_X;
    assign axis_next = r_axis ? S_PMX : S_INIT;

    // One vectoring micro-rotation; the arithmetic shifts round towards minus
    // infinity, as the rotation is defined.
    assign sh_x   = r_cy >>> r_iter;
    assign sh_y   = r_cx >>> r_iter;
    assign atan_z = signed'(Z_W'(ATAN_TAB[r_iter]));

    // Offset angle and its clamp decisions.
    assign n_full  = r_z + sel_off;
    assign frac_lo = (n_full <= 0);
    assign frac_hi = (n_full >= sel_lim);

    // The reciprocal product undershoots the true quotient by at most one.
    assign q0    = r_prod[RECIP_SH +: FRAC_W];
    assign rem   = (NUM_W + 2)'(r_num) - (NUM_W + 2)'(q0) * (NUM_W + 2)'(sel_div);
    assign div_q = q0 + FRAC_W'(rem >= (NUM_W + 2)'(sel_div));

    // Shared multiplier, operands chosen by the sequencer.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DMUL: begin
                mul_a = sel_recip;
                mul_b = MUL_B_W'(r_num);
            end
            S_PMX: begin
                mul_a = MUL_A_W'(r_pane_width);
                mul_b = MUL_B_W'(r_fx);
            end
            S_PMY: begin
                mul_a = MUL_A_W'(r_pane_height);
                mul_b = MUL_B_W'(r_fy);
            end
            S_AMX: begin
                mul_a = RECIP_L;
                mul_b = MUL_B_W'(sum_x);
            end
            S_AMY: begin
                mul_a = RECIP_L;
                mul_b = MUL_B_W'(sum_y);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Column: origin plus the scaled fraction, saturated at the widest column.
    assign px_sum = (PIX_W + 1)'(r_x_origin) + (PIX_W + 1)'(r_prod[16 +: PIX_W]);
    assign px     = px_sum[PIX_W] ? PIX_MAX : px_sum[PIX_W-1:0];

    // Row: origin minus the scaled fraction, saturated at zero. The origin alone
    // stays below 2^30, so a non-negative row always fits the pixel width.
    assign rowq = signed'({2'b00, r_y_origin, 16'h0000})
                - signed'({2'b00, r_prod[29:0]});
    assign py   = rowq[31] ? '0 : rowq[29:16];

    // Ring average: reciprocal product followed by one correction step.
    assign asum = (r_state == S_ACY) ? sum_y : sum_x;
    assign aq0  = (PIX_W + 1)'(r_prod >> SUM_W);
    assign arem = (SUM_W + 1)'(asum) - (SUM_W + 1)'(aq0) * LEN_V;
    assign aq   = aq0 + (PIX_W + 1)'(arem >= LEN_V);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = (r_dy > 0) ? S_ROT : S_FRAC;
            end
            S_ROT: begin
                if (r_iter == ITER_LAST) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                n_state = (frac_lo || frac_hi) ? axis_next : S_DMUL;
            end
            S_DMUL: n_state = S_DCOR;
            S_DCOR: n_state = axis_next;
            S_PMX:  n_state = S_PMY;
            S_PMY:  n_state = S_ROW;
            S_ROW:  n_state = S_RING;
            S_RING: n_state = S_AMX;
            S_AMX:  n_state = S_AMY;
            S_AMY:  n_state = S_ACY;
            S_ACY:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_dir.ready = 1'b0;
        mul_en      = 1'b0;
        ring_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                i_dir.ready = 1'b1;
                ring_ctl.rd = i_dir.valid;
            end
            S_DMUL, S_PMX, S_PMY, S_AMX, S_AMY: begin
                mul_en = 1'b1;
            end
            S_RING: begin
                ring_ctl.wr = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && o_cursor.ready) begin
            n_out_vld = 1'b0;
        end
        if (out_load) begin
            n_out_vld = 1'b1;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_axis        <= 1'b0;
            r_iter        <= '0;
            r_out_vld     <= 1'b0;
            r_x_origin    <= X_ORIGIN_RST;
            r_y_origin    <= Y_ORIGIN_RST;
            r_pane_width  <= PANE_WIDTH_RST;
            r_pane_height <= PANE_HEIGHT_RST;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                end
                S_INIT: begin
                    r_iter <= '0;
                end
                S_ROT: begin
                    r_iter <= r_iter + 1'b1;
                end
                S_FRAC, S_DCOR: begin
                    if (n_state == S_INIT) begin
                        r_axis <= 1'b1;
                    end
                end
                default: begin
                    r_iter <= r_iter;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_ORIGIN:    r_x_origin    <= i_cfg_data;
                    CFG_Y_ORIGIN:    r_y_origin    <= i_cfg_data;
                    CFG_PANE_WIDTH:  r_pane_width  <= i_cfg_data;
                    CFG_PANE_HEIGHT: r_pane_height <= i_cfg_data;
                    default: begin
                        r_x_origin <= r_x_origin;
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (out_load) begin
            r_cur_x <= r_avg_x;
            r_cur_y <= r_avg_y;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_dx <= i_dir.dir_x;
                    r_dy <= i_dir.dir_y;
                    r_dz <= i_dir.dir_z;
                end
            end
            S_INIT: begin
                // The rotation starts from (forward, lateral) scaled by 256, sign-extended.
                r_cx <= CX_W'(signed'({r_dy, 8'h00}));
                r_cy <= CX_W'(signed'({comp, 8'h00}));
                if (r_dy > 0) begin
                    r_z <= '0;
                end else if (r_dy == 0) begin
                    if (comp > 0) begin
                        r_z <= DEG90;
                    end else if (comp < 0) begin
                        r_z <= -DEG90;
                    end else begin
                        r_z <= '0;
                    end
                end else begin
                    // Pointing backwards: a half turn, sign taken from the component.
                    r_z <= (comp >= 0) ? DEG180 : -DEG180;
                end
            end
            S_ROT: begin
                if (!r_cy[CX_W-1]) begin
                    r_cx <= r_cx + sh_x;
                    r_cy <= r_cy - sh_y;
                    r_z  <= r_z + atan_z;
                end else begin
                    r_cx <= r_cx - sh_x;
                    r_cy <= r_cy + sh_y;
                    r_z  <= r_z - atan_z;
                end
            end
            S_FRAC: begin
                r_num <= n_full[NUM_W-1:0];
                if (frac_lo) begin
                    if (r_axis) r_fy <= '0;
                    else        r_fx <= '0;
                end else if (frac_hi) begin
                    if (r_axis) r_fy <= ONE_Q16;
                    else        r_fx <= ONE_Q16;
                end
            end
            S_DCOR: begin
                if (r_axis) r_fy <= div_q;
                else        r_fx <= div_q;
            end
            S_PMY: begin
                r_px <= px;
            end
            S_ROW: begin
                r_py <= py;
            end
            S_AMY: begin
                r_avg_x <= aq[PIX_W-1:0];
            end
            S_ACY: begin
                r_avg_y <= aq[PIX_W-1:0];
            end
            default: begin
                r_num <= r_num;
            end
        endcase
    end

    assign o_cursor.valid    = r_out_vld;
    assign o_cursor.cursor_x = r_cur_x;
    assign o_cursor.cursor_y = r_cur_y;

    // Once an item is taken the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_dir.ready)
        else $error("input ready straight after a transaction");

    // The rotation counter never runs past the configured iteration count.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_iter <= ITER_LAST))
        else $error("rotation counter past last iteration");

    // Both fractions are within [0, 1] by the time the pixel maths starts.
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PMY) |-> ((r_fx <= ONE_Q16) && (r_fy <= ONE_Q16)))
        else $error("deflection fraction above one");

    // A delivered result is not presented again unless a new one is loaded.
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_cursor.ready && (r_state != S_DONE)) |=> !r_out_vld)
        else $error("result repeated after its transaction");

endmodule
